>>> src/hpm_pkg.sv
// hpm_pkg: shared types, codes and constants of the hysteresis period meter.
// Used by every module under src but hpm_fifo; it depends on nothing else.
package hpm_pkg;

  // Band divisor and the record length at which the sample index saturates.
  localparam int SPAN_DIVISOR = 4;
  localparam int MAX_RECORD   = 65536;

  // Depth of the band pipeline, from a register write to a settled band.
  localparam int BAND_LAT = 3;

  // Reciprocal used to divide a 16-bit magnitude by SPAN_DIVISOR (up to 64):
  // floor(a / D) == (a * ceil(2^22 / D)) >> 22 holds for every a below 2^16.
  localparam int RECIP_SHIFT = 22;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((2 ** RECIP_SHIFT + SPAN_DIVISOR - 1) / SPAN_DIVISOR);

  localparam logic [15:0] IDX_MAX  = 16'(MAX_RECORD - 1);
  localparam logic [10:0] EDGE_CAP = 11'd1024;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FLAT = 2'd1,
    ST_FEW  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CFG_SIG_MIN      = 3'd0,
    CFG_SIG_MAX      = 3'd1,
    CFG_SIG_MEAN     = 3'd2,
    CFG_DEAD_BAND    = 3'd3,
    CFG_SETTLE_COUNT = 3'd4,
    CFG_EDGE_LIMIT   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] sig_min;
    logic [15:0] sig_max;
    logic [15:0] sig_mean;
    logic [11:0] dead_band;
    logic [7:0]  settle_count;
    logic [10:0] edge_limit;
  } cfg_t;

  typedef struct packed {
    logic [15:0] lower;
    logic [15:0] upper;
    logic        flat;
  } band_t;

  // One classified sample, handed from the front end to the edge tracker.
  typedef struct packed {
    logic [15:0] idx;
    logic        gt;        // above the upper limit
    logic        le;        // at or below the lower limit
    logic        search;    // edge search is active at this index
    logic        set_side;  // the start vote decides the side here
    logic        side_val;  // outcome of the vote
    logic        last;
    logic        flat;
  } cls_t;

  typedef struct packed {
    status_t     status;
    logic [9:0]  captured_periods;
    logic [15:0] counted_periods;
    logic [15:0] captured_span;
    logic [15:0] total_span;
    logic [31:0] sum_sq_periods;
  } res_t;

endpackage

>>> src/hysteresis_period_meter.sv
// hysteresis_period_meter: top level of the period meter. Holds the record
// registers and joins front end, tracker and queues. Depends on hpm_pkg,
// hpm_fifo, hpm_band (through hpm_front), hpm_front and hpm_back.
//
//   channel  | ports                                          | handshake
//   ---------+------------------------------------------------+------------------------
//   samples  | sample, last                                   | push / full
//   results  | status, captured_periods, counted_periods,     | empty / pop
//            | captured_span, total_span, sum_sq_periods      |
//   config   | cfg_index, cfg_data                            | cfg_write, no wait
//
// One sample beat is taken per clock while full is low. The front end holds
// each sample in a delay line as deep as the band pipeline, then classifies
// it; the tracker follows one beat per clock while the result queue has room,
// and the square and accumulate stages trail behind it.
// Reset clears all record state and loads the register defaults; full is
// high while rst is high. A stalled result side fills the queues and then
// raises full; nothing is dropped.
module hysteresis_period_meter #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        push,
  output logic        full,
  input  logic [15:0] sample,
  input  logic        last,

  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [9:0]  captured_periods,
  output logic [15:0] counted_periods,
  output logic [15:0] captured_span,
  output logic [15:0] total_span,
  output logic [31:0] sum_sq_periods,

  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CLS_W = $bits(hpm_pkg::cls_t);
  localparam int RES_W = $bits(hpm_pkg::res_t);

  hpm_pkg::cfg_t cfg;

  logic             front_ready;
  logic             in_valid;
  logic             cls_push;
  hpm_pkg::cls_t    cls;
  logic             mid_full;
  logic             mid_empty;
  logic [CLS_W-1:0] mid_dout;
  hpm_pkg::cls_t    head;
  logic             back_pop;

  logic             out_full;
  logic             res_push;
  hpm_pkg::res_t    res;
  logic [RES_W-1:0] out_dout;
  hpm_pkg::res_t    out_res;

  // Record registers: the user must change them only between records (the block
  // does not enforce it); so each sample sees its record's band and edge limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sig_min      <= 16'd0;
      cfg.sig_max      <= 16'd65535;
      cfg.sig_mean     <= 16'd32768;
      cfg.dead_band    <= 12'd16;
      cfg.settle_count <= 8'd8;
      cfg.edge_limit   <= 11'd64;
    end else if (cfg_write) begin
      unique case (cfg_index)
        hpm_pkg::CFG_SIG_MIN:      cfg.sig_min      <= cfg_data;
        hpm_pkg::CFG_SIG_MAX:      cfg.sig_max      <= cfg_data;
        hpm_pkg::CFG_SIG_MEAN:     cfg.sig_mean     <= cfg_data;
        hpm_pkg::CFG_DEAD_BAND:    cfg.dead_band    <= cfg_data[11:0];
        hpm_pkg::CFG_SETTLE_COUNT: cfg.settle_count <= cfg_data[7:0];
        hpm_pkg::CFG_EDGE_LIMIT:   cfg.edge_limit   <= cfg_data[10:0];
        default: begin
        end
      endcase
    end
  end

  // Input side: a beat is taken on push while full is low.
  assign full     = rst || !front_ready;
  assign in_valid = push && !full;

  hpm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .sample   (sample),
    .last     (last),
    .ready    (front_ready),
    .q_full   (mid_full),
    .cls_push (cls_push),
    .cls      (cls)
  );

  // Queue of classified samples between the front end and the tracker.
  hpm_fifo #(
    .WIDTH (CLS_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cls_push),
    .din   (cls),
    .full  (mid_full),
    .pop   (back_pop),
    .dout  (mid_dout),
    .empty (mid_empty)
  );

  assign head = hpm_pkg::cls_t'(mid_dout);

  hpm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .edge_limit (cfg.edge_limit),
    .head_valid (!mid_empty),
    .head       (head),
    .pop        (back_pop),
    .out_full   (out_full),
    .res_push   (res_push),
    .res        (res)
  );

  // Result queue: decouples the tracker from a slow consumer.
  hpm_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_dout),
    .empty (empty)
  );

  assign out_res          = hpm_pkg::res_t'(out_dout);
  assign status           = out_res.status;
  assign captured_periods = out_res.captured_periods;
  assign counted_periods  = out_res.counted_periods;
  assign captured_span    = out_res.captured_span;
  assign total_span       = out_res.total_span;
  assign sum_sq_periods   = out_res.sum_sq_periods;

endmodule

>>> src/hpm_fifo.sv
// hpm_fifo: small first-in first-out queue of packed beats.
// Generic; used between front end and tracker and on the result side.
module hpm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             wr;
  logic             rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (wr && !rd) begin
        count <= count + CW'(1);
      end else if (rd && !wr) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

>>> src/hpm_band.sv
// hpm_band: three-stage pipeline that turns the record registers into the
// hysteresis band limits and the flat flag. Depends on hpm_pkg.
module hpm_band (
  input  logic          clk,
  input  hpm_pkg::cfg_t cfg,
  output hpm_pkg::band_t band
);

  logic signed [16:0] dl;
  logic signed [16:0] du;

  // Stage 1: signed spans, their magnitudes, and the fallback limits.
  logic               s1_neg_l, s1_neg_u, s1_flat;
  logic [15:0]        s1_mag_l, s1_mag_u, s1_me, s1_lo_fb, s1_up_fb;
  logic [16:0]        s1_lo_lim;
  logic signed [17:0] s1_hi_lim;

  // Stage 2: spans scaled by the reciprocal of the divisor.
  localparam int PW = 16 + hpm_pkg::RECIP_W;
  logic               s2_neg_l, s2_neg_u, s2_flat;
  logic [PW-1:0]      s2_prod_l, s2_prod_u;
  logic [15:0]        s2_me, s2_lo_fb, s2_up_fb;
  logic [16:0]        s2_lo_lim;
  logic signed [17:0] s2_hi_lim;

  logic [15:0] ql, qu, lo_raw, up_raw;

  assign dl = $signed({1'b0, cfg.sig_mean}) - $signed({1'b0, cfg.sig_min});
  assign du = $signed({1'b0, cfg.sig_max}) - $signed({1'b0, cfg.sig_mean});

  always_ff @(posedge clk) begin
    s1_neg_l  <= dl[16];
    s1_neg_u  <= du[16];
    s1_mag_l  <= dl[16] ? 16'(-dl) : dl[15:0];
    s1_mag_u  <= du[16] ? 16'(-du) : du[15:0];
    s1_me     <= cfg.sig_mean;
    s1_lo_fb  <= cfg.sig_mean - {5'd0, cfg.dead_band[11:1]};
    s1_up_fb  <= cfg.sig_mean + {5'd0, cfg.dead_band[11:1]};
    s1_lo_lim <= {1'b0, cfg.sig_min} + {5'd0, cfg.dead_band};
    s1_hi_lim <= $signed({2'b00, cfg.sig_max}) - $signed({6'd0, cfg.dead_band});
    s1_flat   <= ($signed({1'b0, cfg.sig_max}) - $signed({1'b0, cfg.sig_min}))
                 <= $signed({5'd0, cfg.dead_band});
  end

  always_ff @(posedge clk) begin
    s2_neg_l  <= s1_neg_l;
    s2_neg_u  <= s1_neg_u;
    s2_prod_l <= PW'(s1_mag_l) * PW'(hpm_pkg::RECIP);
    s2_prod_u <= PW'(s1_mag_u) * PW'(hpm_pkg::RECIP);
    s2_me     <= s1_me;
    s2_lo_fb  <= s1_lo_fb;
    s2_up_fb  <= s1_up_fb;
    s2_lo_lim <= s1_lo_lim;
    s2_hi_lim <= s1_hi_lim;
    s2_flat   <= s1_flat;
  end

  // Stage 3: apply the signs (division rounds toward zero) and fall back to
  // the dead band around the mean when a limit crowds the extreme.
  assign ql     = s2_prod_l[hpm_pkg::RECIP_SHIFT +: 16];
  assign qu     = s2_prod_u[hpm_pkg::RECIP_SHIFT +: 16];
  assign lo_raw = s2_neg_l ? s2_me + ql : s2_me - ql;
  assign up_raw = s2_neg_u ? s2_me - qu : s2_me + qu;

  always_ff @(posedge clk) begin
    band.lower <= ({1'b0, lo_raw} <= s2_lo_lim) ? s2_lo_fb : lo_raw;
    band.upper <= ($signed({2'b00, up_raw}) >= s2_hi_lim) ? s2_up_fb : up_raw;
    band.flat  <= s2_flat;
  end

endmodule

>>> src/hpm_front.sv
// hpm_front: accepts samples, delays them while the band settles, and
// classifies each against the band, including the start vote.
// Depends on hpm_pkg and hpm_band.
module hpm_front (
  input  logic          clk,
  input  logic          rst,
  input  hpm_pkg::cfg_t cfg,
  input  logic          in_valid,
  input  logic [15:0]   sample,
  input  logic          last,
  output logic          ready,
  input  logic          q_full,
  output logic          cls_push,
  output hpm_pkg::cls_t cls
);

  localparam int L = hpm_pkg::BAND_LAT;

  hpm_pkg::band_t band;

  logic [L-1:0] v;
  logic [L-1:0] en;
  logic [L-1:0] lst;
  logic [15:0]  smp [L];

  logic [15:0] idx;
  logic [8:0]  vote;
  logic [8:0]  vote_next;
  logic        gt;
  logic        le;

  hpm_band u_band (
    .clk  (clk),
    .cfg  (cfg),
    .band (band)
  );

  // A stage moves when it is empty or when the stage after it moves.
  always_comb begin
    en[L-1] = !v[L-1] || !q_full;
    for (int j = L - 2; j >= 0; j--) begin
      en[j] = !v[j] || en[j+1];
    end
  end

  assign ready    = en[0];
  assign cls_push = v[L-1] && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int j = 1; j < L; j++) begin
        if (en[j]) begin
          v[j] <= v[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      smp[0] <= sample;
      lst[0] <= last;
    end
    for (int j = 1; j < L; j++) begin
      if (en[j]) begin
        smp[j] <= smp[j-1];
        lst[j] <= lst[j-1];
      end
    end
  end

  assign gt = smp[L-1] > band.upper;
  assign le = smp[L-1] <= band.lower;

  // Sample 0 votes alone and, for a nonzero settle count, in the settle window.
  assign vote_next = vote + 9'(idx == 16'd0 && gt)
                   + 9'(idx < {8'd0, cfg.settle_count} && gt);

  always_comb begin
    cls.idx      = idx;
    cls.gt       = gt;
    cls.le       = le;
    cls.search   = idx >= {8'd0, cfg.settle_count};
    cls.set_side = (cfg.settle_count == 8'd0 && idx == 16'd0)
                || ({1'b0, idx} + 17'd1 == {9'd0, cfg.settle_count});
    cls.side_val = vote_next > {2'b00, cfg.settle_count[7:1]};
    cls.last     = lst[L-1];
    cls.flat     = band.flat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      vote <= '0;
    end else if (cls_push) begin
      if (lst[L-1]) begin
        idx  <= '0;
        vote <= '0;
      end else begin
        idx  <= (idx != hpm_pkg::IDX_MAX) ? idx + 16'd1 : idx;
        vote <= vote_next;
      end
    end
  end

endmodule

>>> src/hpm_back.sv
// hpm_back: edge tracker. Follows the side of the signal, counts and captures
// upward crossings, squares the periods and builds the record result.
// Depends on hpm_pkg.
module hpm_back (
  input  logic          clk,
  input  logic          rst,
  input  logic [10:0]   edge_limit,
  input  logic          head_valid,
  input  hpm_pkg::cls_t head,
  output logic          pop,
  input  logic          out_full,
  output logic          res_push,
  output hpm_pkg::res_t res
);

  logic        en;

  logic        above;
  logic [9:0]  cap;
  logic [15:0] all_edges;
  logic [15:0] first_pos;
  logic [15:0] prev_pos;
  logic [15:0] latest_pos;
  logic [31:0] acc;

  logic        above_next;
  logic [9:0]  cap_next;
  logic [15:0] all_next;
  logic [15:0] first_next;
  logic [15:0] prev_next;
  logic [15:0] latest_next;
  logic [31:0] acc_next;

  logic [10:0] lim;
  logic        cap_ok;
  logic        side;
  logic        rise;
  logic        fall;
  logic        capture;
  logic [15:0] d;

  hpm_pkg::status_t r_status;
  logic [9:0]       r_cap;
  logic [15:0]      r_cnt, r_cspan, r_tspan;
  logic             r_keep;

  logic                s1_v, s1_last, s1_dv, s1_keep;
  logic [15:0]         s1_d;
  hpm_pkg::status_t    s1_status;
  logic [9:0]          s1_cap;
  logic [15:0]         s1_cnt, s1_cspan, s1_tspan;

  logic                s2_v, s2_last, s2_dv, s2_keep;
  logic [31:0]         s2_sq;
  hpm_pkg::status_t    s2_status;
  logic [9:0]          s2_cap;
  logic [15:0]         s2_cnt, s2_cspan, s2_tspan;

  logic [32:0] sum_ext;

  assign en  = !out_full;
  assign pop = en && head_valid;

  assign lim    = (edge_limit > hpm_pkg::EDGE_CAP) ? hpm_pkg::EDGE_CAP : edge_limit;
  assign cap_ok = (lim != 11'd0) && ({1'b0, cap} < lim - 11'd1);

  always_comb begin
    side        = head.set_side ? head.side_val : above;
    rise        = head.search && !side && head.gt;
    fall        = head.search && side && head.le;
    capture     = rise && cap_ok;
    above_next  = rise ? 1'b1 : (fall ? 1'b0 : side);
    first_next  = (rise && all_edges == 16'd0) ? head.idx : first_pos;
    prev_next   = capture ? head.idx : prev_pos;
    cap_next    = cap + 10'(capture);
    latest_next = rise ? head.idx : latest_pos;
    all_next    = (rise && all_edges != 16'hFFFF) ? all_edges + 16'd1 : all_edges;
    d           = head.idx - prev_pos;
  end

  always_comb begin
    r_status = hpm_pkg::ST_OK;
    r_cap    = '0;
    r_cnt    = '0;
    r_cspan  = '0;
    r_tspan  = '0;
    r_keep   = 1'b0;
    priority if (head.flat) begin
      r_status = hpm_pkg::ST_FLAT;
    end else begin
      if (all_next != 16'd0) begin
        r_cnt   = all_next - 16'd1;
        r_tspan = latest_next - first_next;
      end
      if (cap_next <= 10'd1) begin
        r_status = hpm_pkg::ST_FEW;
      end else begin
        r_cap   = cap_next - 10'd1;
        r_cspan = prev_next - first_next;
        r_keep  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      above      <= 1'b0;
      cap        <= '0;
      all_edges  <= '0;
      first_pos  <= '0;
      prev_pos   <= '0;
      latest_pos <= '0;
    end else if (pop) begin
      if (head.last) begin
        above      <= 1'b0;
        cap        <= '0;
        all_edges  <= '0;
        first_pos  <= '0;
        prev_pos   <= '0;
        latest_pos <= '0;
      end else begin
        above      <= above_next;
        cap        <= cap_next;
        all_edges  <= all_next;
        first_pos  <= first_next;
        prev_pos   <= prev_next;
        latest_pos <= latest_next;
      end
    end
  end

  // Square and accumulate run two stages behind the tracker, in order.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else if (en) begin
      s1_v <= head_valid;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_last   <= head.last;
      s1_dv     <= capture && (cap != 10'd0);
      s1_d      <= d;
      s1_keep   <= r_keep;
      s1_status <= r_status;
      s1_cap    <= r_cap;
      s1_cnt    <= r_cnt;
      s1_cspan  <= r_cspan;
      s1_tspan  <= r_tspan;

      s2_last   <= s1_last;
      s2_dv     <= s1_dv;
      s2_sq     <= {16'd0, s1_d} * {16'd0, s1_d};
      s2_keep   <= s1_keep;
      s2_status <= s1_status;
      s2_cap    <= s1_cap;
      s2_cnt    <= s1_cnt;
      s2_cspan  <= s1_cspan;
      s2_tspan  <= s1_tspan;
    end
  end

  assign sum_ext  = {1'b0, acc} + (s2_dv ? {1'b0, s2_sq} : 33'd0);
  assign acc_next = sum_ext[32] ? 32'hFFFF_FFFF : sum_ext[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (en && s2_v) begin
      acc <= s2_last ? 32'd0 : acc_next;
    end
  end

  assign res_push = en && s2_v && s2_last;

  always_comb begin
    res.status           = s2_status;
    res.captured_periods = s2_cap;
    res.counted_periods  = s2_cnt;
    res.captured_span    = s2_cspan;
    res.total_span       = s2_tspan;
    res.sum_sq_periods   = s2_keep ? acc_next : 32'd0;
  end

  a_cap_within_all: assert property (@(posedge clk) disable iff (rst)
    {6'd0, cap} <= all_edges)
    else $error("captured edge count exceeds detected edge count");

  a_clear_on_last: assert property (@(posedge clk) disable iff (rst)
    (pop && head.last) |=> (cap == 10'd0 && all_edges == 16'd0 && !above))
    else $error("record state not cleared after last sample");

  a_prev_after_first: assert property (@(posedge clk) disable iff (rst)
    (cap != 10'd0) |-> (prev_pos >= first_pos))
    else $error("captured edge lies before first edge");

  a_ok_has_periods: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.status == hpm_pkg::ST_OK) |-> (res.captured_periods != 10'd0))
    else $error("ok result without captured periods");

  a_flat_zeroed: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.status == hpm_pkg::ST_FLAT)
      |-> (res.counted_periods == 16'd0 && res.sum_sq_periods == 32'd0))
    else $error("flat result carries counts");

endmodule

>>> bench/hpm_checker.sv
`timescale 1ns / 1ps
// hpm_checker: watches the sample, result and register ports of the period meter,
// predicts one result per record and compares every result beat field by field.
// Depends on hpm_pkg for the register layout, register indexes and status codes.
module hpm_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [15:0] sample,
  input  logic        last,
  input  logic        empty,
  input  logic        pop,
  input  logic [1:0]  status,
  input  logic [9:0]  captured_periods,
  input  logic [15:0] counted_periods,
  input  logic [15:0] captured_span,
  input  logic [15:0] total_span,
  input  logic [31:0] sum_sq_periods,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          pending
);

  hpm_pkg::cfg_t regs;

  // Record state of the predictor.
  logic [15:0] pos;
  logic        high_side;
  logic [8:0]  votes;
  logic [9:0]  cap_edges;
  logic [15:0] edge_total;
  logic [15:0] first_pos;
  logic [15:0] prev_pos;
  logic [15:0] newest_pos;
  logic [31:0] sq_acc;

  hpm_pkg::res_t reports_due[$];
  int            fail_count = 0;

  assign mismatches = fail_count;

  task automatic restart_record();
    pos        = '0;
    high_side  = 1'b0;
    votes      = '0;
    cap_edges  = '0;
    edge_total = '0;
    first_pos  = '0;
    prev_pos   = '0;
    newest_pos = '0;
    sq_acc     = '0;
  endtask

  // Classifies one sample against the band and updates the edge bookkeeping;
  // the final sample of a record queues the report it produces.
  task automatic track_crossing(input logic [15:0] s, input logic lst);
    int            mn, mx, me, db, st, i, lower, upper, lim;
    longint        span, acc;
    hpm_pkg::res_t r;
    mn = regs.sig_min;
    mx = regs.sig_max;
    me = regs.sig_mean;
    db = regs.dead_band;
    st = regs.settle_count;
    i  = pos;

    // Band limits wrap to 16 bits; a band too close to the extremes falls back
    // to half the dead band around the mean.
    lower = (me - (me - mn) / hpm_pkg::SPAN_DIVISOR) & 32'hFFFF;
    if (lower <= mn + db) lower = (me - db / 2) & 32'hFFFF;
    upper = (me + (mx - me) / hpm_pkg::SPAN_DIVISOR) & 32'hFFFF;
    if (upper >= mx - db) upper = (me + db / 2) & 32'hFFFF;

    // Start vote; the first sample weighs twice under a nonzero settle count.
    if (i == 0 && s > upper) votes++;
    if (i < st && s > upper) votes++;
    if ((st == 0 && i == 0) || i + 1 == st) high_side = votes > (st >> 1);

    if (i >= st) begin
      if (high_side) begin
        if (s <= lower) high_side = 1'b0;
      end else if (s > upper) begin
        lim = (regs.edge_limit > 1024) ? 1024 : regs.edge_limit;
        high_side = 1'b1;
        if (edge_total == 0) first_pos = pos;
        if (lim >= 1 && cap_edges < lim - 1) begin
          if (cap_edges > 0) begin
            span   = i - prev_pos;
            acc    = sq_acc + span * span;
            sq_acc = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
          end
          prev_pos = pos;
          cap_edges++;
        end
        newest_pos = pos;
        if (edge_total != 16'hFFFF) edge_total++;
      end
    end

    if (i < hpm_pkg::MAX_RECORD - 1) pos++;

    if (lst) begin
      r = '0;
      if (mx - mn <= db) begin
        r.status = hpm_pkg::ST_FLAT;
      end else begin
        if (edge_total > 0) begin
          r.counted_periods = edge_total - 16'd1;
          r.total_span      = newest_pos - first_pos;
        end
        if (cap_edges <= 1) begin
          r.status = hpm_pkg::ST_FEW;
        end else begin
          r.status           = hpm_pkg::ST_OK;
          r.captured_periods = cap_edges - 10'd1;
          r.captured_span    = prev_pos - first_pos;
          r.sum_sq_periods   = sq_acc;
        end
      end
      reports_due.push_back(r);
      restart_record();
    end
  endtask

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", field, want, got);
    end
  endfunction

  task automatic check_report();
    hpm_pkg::res_t want;
    if (reports_due.size() == 0) begin
      fail_count++;
      $error("result beat arrived with no record report outstanding");
    end else begin
      want = reports_due.pop_front();
      check_field("status", want.status, status);
      check_field("captured_periods", want.captured_periods, captured_periods);
      check_field("counted_periods", want.counted_periods, counted_periods);
      check_field("captured_span", want.captured_span, captured_span);
      check_field("total_span", want.total_span, total_span);
      check_field("sum_sq_periods", want.sum_sq_periods, sum_sq_periods);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs.sig_min      = 16'd0;
      regs.sig_max      = 16'd65535;
      regs.sig_mean     = 16'd32768;
      regs.dead_band    = 12'd16;
      regs.settle_count = 8'd8;
      regs.edge_limit   = 11'd64;
      restart_record();
      reports_due.delete();
    end else begin
      if (cfg_write) begin
        case (hpm_pkg::cfg_idx_t'(cfg_index))
          hpm_pkg::CFG_SIG_MIN:      regs.sig_min      = cfg_data;
          hpm_pkg::CFG_SIG_MAX:      regs.sig_max      = cfg_data;
          hpm_pkg::CFG_SIG_MEAN:     regs.sig_mean     = cfg_data;
          hpm_pkg::CFG_DEAD_BAND:    regs.dead_band    = cfg_data[11:0];
          hpm_pkg::CFG_SETTLE_COUNT: regs.settle_count = cfg_data[7:0];
          hpm_pkg::CFG_EDGE_LIMIT:   regs.edge_limit   = cfg_data[10:0];
          default: ;
        endcase
      end
      if (push && !full) track_crossing(sample, last);
      if (pop && !empty) check_report();
    end
    pending <= reports_due.size();
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// testbench: drives records of samples and register settings into the period
// meter and gives the verdict. Depends on hpm_pkg, hysteresis_period_meter and hpm_checker.
module testbench;

  // Idle wait after every record has reported, before touching the registers or ending.
  localparam int          DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int          MIN_ITEMS    = 1350;
  localparam int          MIN_RECORDS  = 20;
  // An index with no register behind it; writes there must change nothing.
  localparam logic [2:0]  CFG_UNUSED   = 3'd7;

  typedef enum logic [1:0] {POP_ALWAYS, POP_HALF, POP_RARE, POP_HOLD} pop_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [15:0] sample = '0;
  logic        last = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  status;
  logic [9:0]  captured_periods;
  logic [15:0] counted_periods;
  logic [15:0] captured_span;
  logic [15:0] total_span;
  logic [31:0] sum_sq_periods;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int mismatches;
  int pending;

  // Register image written by the next register phase, indexed by register.
  logic [15:0] reg_val [6];

  // Beats of the records of the current phase.
  logic [15:0] beat_sample[$];
  logic        beat_last[$];

  int          burst_left = 0;
  int          items_sent = 0;
  int          records_sent = 0;
  int unsigned cycle_count = 0;
  pop_mode_t   pop_mode = POP_ALWAYS;
  int          pop_hold = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  hysteresis_period_meter dut (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .sample           (sample),
    .last             (last),
    .empty            (empty),
    .pop              (pop),
    .status           (status),
    .captured_periods (captured_periods),
    .counted_periods  (counted_periods),
    .captured_span    (captured_span),
    .total_span       (total_span),
    .sum_sq_periods   (sum_sq_periods),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  hpm_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .sample           (sample),
    .last             (last),
    .empty            (empty),
    .pop              (pop),
    .status           (status),
    .captured_periods (captured_periods),
    .counted_periods  (counted_periods),
    .captured_span    (captured_span),
    .total_span       (total_span),
    .sum_sq_periods   (sum_sq_periods),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  // Result side: the receiver picks a random stall mode for a random spell, from
  // taking every beat to holding off completely. The long holds back up the
  // result queue until full reaches the sender.
  always @(posedge clk) begin
    if (pop_hold == 0) begin
      pop_mode <= pop_mode_t'($urandom_range(0, 3));
      pop_hold <= $urandom_range(16, 200);
    end else begin
      pop_hold <= pop_hold - 1;
    end
    case (pop_mode)
      POP_ALWAYS: pop <= 1'b1;
      POP_HALF:   pop <= 1'($urandom_range(0, 1));
      POP_RARE:   pop <= ($urandom_range(0, 7) == 0);
      default:    pop <= 1'b0;
    endcase
  end

  // Watchdog: a run that hangs on a handshake or loses a result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Sends one sample beat. The sender works in bursts; between bursts push
  // drops for a random gap, so it is never lowered and raised in the same
  // step. About one burst in five is long, giving stretches with no idling.
  task automatic send_beat(input logic [15:0] s, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 10);
      burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 40);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push   <= 1'b1;
    sample <= s;
    last   <= lst;
    @(posedge clk);
    while (full) @(posedge clk);
    burst_left--;
    items_sent++;
    if (lst) records_sent++;
  endtask

  task automatic add_beat(input int s, input logic lst);
    beat_sample.push_back(s[15:0]);
    beat_last.push_back(lst);
  endtask

  task automatic play_beats();
    while (beat_sample.size() > 0) send_beat(beat_sample.pop_front(), beat_last.pop_front());
  endtask

  task automatic set_regs(input int mn, input int mx, input int me,
                          input int db, input int st, input int el);
    reg_val[hpm_pkg::CFG_SIG_MIN]      = 16'(mn);
    reg_val[hpm_pkg::CFG_SIG_MAX]      = 16'(mx);
    reg_val[hpm_pkg::CFG_SIG_MEAN]     = 16'(me);
    reg_val[hpm_pkg::CFG_DEAD_BAND]    = 16'(db);
    reg_val[hpm_pkg::CFG_SETTLE_COUNT] = 16'(st);
    reg_val[hpm_pkg::CFG_EDGE_LIMIT]   = 16'(el);
  endtask

  // Registers change only with the block idle: every record sent so far has
  // reported, and the pipeline has had time to empty. The clock step before
  // polling lets the checker's count catch up with the final beat.
  task automatic load_registers();
    push <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (int k = 0; k < 6; k++) begin
      cfg_write <= 1'b1;
      cfg_index <= hpm_pkg::cfg_idx_t'(k);
      cfg_data  <= reg_val[k];
      @(posedge clk);
    end
    if ($urandom_range(0, 5) == 0) begin
      cfg_index <= CFG_UNUSED;
      cfg_data  <= 16'($urandom);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  // Builds one to three records and a register setting for them. Most
  // settings take the true minimum, maximum and mean of the records, so the
  // band sits inside the swing and the edge search sees real crossings.
  // Records are mostly noisy square waves, some pure noise, and a few very
  // short or long enough to outlast the largest settle count.
  task automatic plan_phase();
    int     nrec, len, run, lo_lvl, hi_lvl, noise, kind, v, mn, mx, cnt;
    bit     at_hi;
    longint total;
    mn    = 65535;
    mx    = 0;
    total = 0;
    cnt   = 0;
    nrec  = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
    for (int r = 0; r < nrec; r++) begin
      case ($urandom_range(0, 9))
        0:       len = 1;
        1:       len = $urandom_range(256, 320);
        default: len = $urandom_range(2, 60);
      endcase
      kind   = $urandom_range(0, 5);
      lo_lvl = $urandom_range(0, 65535);
      hi_lvl = $urandom_range(lo_lvl, 65535);
      if (kind == 5) begin
        lo_lvl = 0;
        hi_lvl = 65535;
      end
      noise = $urandom_range(0, (hi_lvl - lo_lvl) / 3 + 1);
      run   = 0;
      at_hi = 1'($urandom_range(0, 1));
      for (int k = 0; k < len; k++) begin
        if (kind == 4) begin
          v = $urandom_range(0, 65535);
        end else begin
          if (run == 0) begin
            at_hi = !at_hi;
            run   = $urandom_range(1, 8);
          end
          run--;
          v = (at_hi ? hi_lvl : lo_lvl) + int'($urandom_range(0, 2 * noise)) - noise;
          if (v < 0) v = 0;
          if (v > 65535) v = 65535;
        end
        if (v < mn) mn = v;
        if (v > mx) mx = v;
        total += v;
        cnt++;
        add_beat(v, k == len - 1);
      end
    end

    if ($urandom_range(0, 3) != 0) begin
      reg_val[hpm_pkg::CFG_SIG_MIN]  = 16'(mn);
      reg_val[hpm_pkg::CFG_SIG_MAX]  = 16'(mx);
      reg_val[hpm_pkg::CFG_SIG_MEAN] = 16'(total / cnt);
    end else begin
      reg_val[hpm_pkg::CFG_SIG_MIN]  = 16'($urandom);
      reg_val[hpm_pkg::CFG_SIG_MAX]  = 16'($urandom);
      reg_val[hpm_pkg::CFG_SIG_MEAN] = 16'($urandom);
    end
    case ($urandom_range(0, 5))
      0:       reg_val[hpm_pkg::CFG_DEAD_BAND] = 16'd0;
      1:       reg_val[hpm_pkg::CFG_DEAD_BAND] = 16'd4095;
      2:       reg_val[hpm_pkg::CFG_DEAD_BAND] = 16'($urandom_range(0, 4095));
      default: reg_val[hpm_pkg::CFG_DEAD_BAND] = 16'($urandom_range(0, 300));
    endcase
    case ($urandom_range(0, 7))
      0:       reg_val[hpm_pkg::CFG_SETTLE_COUNT] = 16'd0;
      1:       reg_val[hpm_pkg::CFG_SETTLE_COUNT] = 16'd255;
      2:       reg_val[hpm_pkg::CFG_SETTLE_COUNT] = 16'd1;
      default: reg_val[hpm_pkg::CFG_SETTLE_COUNT] = 16'($urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 7))
      0:       reg_val[hpm_pkg::CFG_EDGE_LIMIT] = 16'd0;
      1:       reg_val[hpm_pkg::CFG_EDGE_LIMIT] = 16'd1;
      2:       reg_val[hpm_pkg::CFG_EDGE_LIMIT] = 16'd2;
      3:       reg_val[hpm_pkg::CFG_EDGE_LIMIT] = 16'd1024;
      4:       reg_val[hpm_pkg::CFG_EDGE_LIMIT] = 16'($urandom_range(1025, 2047));
      5:       reg_val[hpm_pkg::CFG_EDGE_LIMIT] = 16'($urandom_range(2, 1024));
      default: reg_val[hpm_pkg::CFG_EDGE_LIMIT] = 16'($urandom_range(2, 12));
    endcase
    // Now and then put junk above the width of the narrow registers; the
    // block keeps only the low bits.
    if ($urandom_range(0, 7) == 0) reg_val[hpm_pkg::CFG_DEAD_BAND][15:12] = 4'($urandom);
    if ($urandom_range(0, 7) == 0) reg_val[hpm_pkg::CFG_SETTLE_COUNT][15:8] = 8'($urandom);
    if ($urandom_range(0, 7) == 0) reg_val[hpm_pkg::CFG_EDGE_LIMIT][15:11] = 5'($urandom);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Registers as they come out of reset: a single-sample record ends long
    // before the vote is over and so reports too few edges.
    add_beat(65535, 1'b1);
    play_beats();

    // Zero settle count with the widest dead band: the first sample alone
    // decides the side, and since it starts high it is not an edge itself.
    set_regs(0, 65535, 32768, 4095, 0, 1024);
    load_registers();
    add_beat(65535, 1'b0);
    add_beat(0, 1'b0);
    add_beat(65535, 1'b0);
    add_beat(0, 1'b0);
    add_beat(65535, 1'b0);
    add_beat(0, 1'b1);
    play_beats();

    // An edge limit above 1024 behaves as 1024; zero dead band.
    set_regs(0, 65535, 32768, 0, 2, 2047);
    load_registers();
    add_beat(0, 1'b0);
    add_beat(65535, 1'b0);
    add_beat(0, 1'b0);
    add_beat(65535, 1'b0);
    add_beat(0, 1'b0);
    add_beat(65535, 1'b1);
    play_beats();

    // Narrow swing against a wide dead band: both limits fall back to half
    // the dead band around the mean. An edge limit of zero captures nothing,
    // but detected edges are still counted.
    set_regs(30000, 35000, 32500, 4095, 1, 0);
    load_registers();
    add_beat(30000, 1'b0);
    add_beat(35000, 1'b0);
    add_beat(30000, 1'b0);
    add_beat(35000, 1'b1);
    play_beats();

    // Maximum below minimum with the mean outside both: a flat signal, and a
    // record far shorter than the largest settle count.
    set_regs(5000, 100, 65535, 0, 255, 2);
    load_registers();
    add_beat(0, 1'b0);
    add_beat(32768, 1'b0);
    add_beat(65535, 1'b1);
    play_beats();

    // A swing exactly equal to the dead band still counts as flat.
    set_regs(1000, 1016, 1008, 16, 8, 64);
    load_registers();
    add_beat(1016, 1'b0);
    add_beat(1000, 1'b1);
    play_beats();

    // Random phases, each with its own register setting.
    while (items_sent < MIN_ITEMS || records_sent < MIN_RECORDS) begin
      plan_phase();
      load_registers();
      play_beats();
    end

    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
